// ----- hw/rtl/texture_sampler_nearest_bilinear_unit_assert.svh -----
// assertion macros for the texture sampler
`ifndef TEXTURE_SAMPLER_NEAREST_BILINEAR_UNIT_ASSERT_SVH
`define TEXTURE_SAMPLER_NEAREST_BILINEAR_UNIT_ASSERT_SVH

// property checked in the same cycle, off during reset
`define TSNB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TSNB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ----- hw/rtl/tsnb_pkg.sv -----
// shared constants, types and functions of the texture sampler
`timescale 1ns / 1ps
`default_nettype none
package tsnb_pkg;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int STORE_DEPTH = 4096;
	localparam int FRAC_BITS = 16;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int IDX_W = 12;
	localparam int SIZE_W = 7;
	localparam int X_W = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
	localparam int Y_W = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
	localparam int CH_W = 17;
	localparam int WORD_W = 34;
	localparam int OPAQUE_B = 32;
	localparam int BLANK_B = 33;
	localparam int FRAC_ONE = 1 << FRAC_BITS;
	localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);
	localparam int ONE_OUT = 65536;
	localparam int ACC_W = CH_W + FRAC_BITS + 2;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [3:0][CH_W-1:0] rgba_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2,
		REG_FILTER   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		FILT_NEAREST  = 1'b0,
		FILT_BILINEAR = 1'b1
	} filt_t;

	typedef struct packed {
		logic valid;
		logic sample;
		logic blank;
	} tsnb_ctl_t;

	// word layout: r,g,b,a bytes, then alpha-is-one flag, then blank flag
	function automatic word_t pack_texel(logic [2:0] cc, logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		word_t w;
		w = '0;
		unique case (cc)
			3'd1: begin
				w[31:0] = {8'd0, b0, b0, b0};
				w[OPAQUE_B] = 1'b1;
			end
			3'd2: w[31:0] = {b1, b0, b0, b0};
			3'd3: begin
				w[31:0] = {8'd0, b2, b1, b0};
				w[OPAQUE_B] = 1'b1;
			end
			3'd4: w[31:0] = {b3, b2, b1, b0};
			default: w[BLANK_B] = 1'b1;
		endcase
		return w;
	endfunction

	function automatic rgba_t unpack_texel(word_t w);
		rgba_t c;
		for (int k = 0; k < 4; k++) begin
			c[k] = w[BLANK_B] ? '0 : {1'b0, w[8*k +: 8], 8'h80};
		end
		if (!w[BLANK_B] && w[OPAQUE_B]) begin
			c[3] = CH_W'(ONE_OUT);
		end
		return c;
	endfunction

	function automatic chan_t blend(chan_t lo, chan_t hi, frac_t f);
		logic [FRAC_BITS:0] g;
		logic [ACC_W-1:0] acc;
		g = (FRAC_BITS+1)'(FRAC_ONE) - (FRAC_BITS+1)'(f);
		acc = ACC_W'(lo) * ACC_W'(g) + ACC_W'(hi) * ACC_W'(f) + ACC_W'(FRAC_HALF);
		return CH_W'(acc >> FRAC_BITS);
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/tsnb_ram.sv -----
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tsnb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tsnb_addr.sv -----
// front stages: item capture, coordinate scaling and texel address generation
`timescale 1ns / 1ps
`default_nettype none
module tsnb_addr import tsnb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic                   take,
	input  wire logic                   cmd,
	input  wire logic [IDX_W-1:0]       texel_index,
	input  wire logic [7:0]             byte0,
	input  wire logic [7:0]             byte1,
	input  wire logic [7:0]             byte2,
	input  wire logic [7:0]             byte3,
	input  wire logic signed [31:0]     coord_s,
	input  wire logic signed [31:0]     coord_t,
	input  wire logic [SIZE_W-1:0]      w,
	input  wire logic [SIZE_W-1:0]      h,
	input  wire logic [2:0]             channel_count,
	input  wire filt_t                  mode,
	input  wire logic                   loaded,
	output tsnb_ctl_t                   ctl_s3,
	output logic [IDX_W-1:0]            idx_s3,
	output word_t                       word_s3,
	output logic [3:0][ADDR_W-1:0]      raddr_s3,
	output frac_t                       fx_s3,
	output frac_t                       fy_s3
);
	localparam int PW = FRAC_BITS + 1 + SIZE_W;

	tsnb_ctl_t ctl_s1, ctl_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	word_t word_s1, word_s2;
	frac_t fs_s1, ft_s1;
	logic [X_W-1:0] x0_s2;
	logic [Y_W-1:0] y0_s2;
	frac_t fx_s2, fy_s2;

	logic [FRAC_BITS:0] ft_inv;
	logic [SIZE_W-1:0] opx, opy;
	logic [FRAC_BITS:0] fty;
	logic [PW-1:0] rnd, px, py;
	logic [X_W-1:0] x0_c;
	logic [Y_W-1:0] y0_c;
	frac_t fx_c, fy_c;
	logic [X_W:0] xi;
	logic [Y_W:0] yi;
	logic [X_W-1:0] x1_c;
	logic [Y_W-1:0] y1_c;

	function automatic logic [ADDR_W-1:0] flat(logic [X_W-1:0] x, logic [Y_W-1:0] y,
			logic [SIZE_W-1:0] wd);
		logic [Y_W+SIZE_W-1:0] p;
		p = (Y_W+SIZE_W)'(y) * (Y_W+SIZE_W)'(wd);
		return ADDR_W'(p) + ADDR_W'(x);
	endfunction

	// scaling: nearest uses size-1 with rounding and flips t, bilinear uses size
	always_comb begin
		ft_inv = (FRAC_BITS+1)'(FRAC_ONE) - (FRAC_BITS+1)'(ft_s1);
		if (mode == FILT_NEAREST) begin
			opx = w - SIZE_W'(1);
			opy = h - SIZE_W'(1);
			fty = ft_inv;
			rnd = PW'(FRAC_HALF);
		end else begin
			opx = w;
			opy = h;
			fty = (FRAC_BITS+1)'(ft_s1);
			rnd = '0;
		end
		px = PW'(fs_s1) * PW'(opx) + rnd;
		py = PW'(fty) * PW'(opy) + rnd;
		x0_c = px[FRAC_BITS +: X_W];
		y0_c = py[FRAC_BITS +: Y_W];
		fx_c = (mode == FILT_NEAREST) ? '0 : px[FRAC_BITS-1:0];
		fy_c = (mode == FILT_NEAREST) ? '0 : py[FRAC_BITS-1:0];
	end

	// upper neighbors wrap to zero at the edge
	always_comb begin
		xi = (X_W+1)'(x0_s2) + (X_W+1)'(1);
		yi = (Y_W+1)'(y0_s2) + (Y_W+1)'(1);
		if (fx_s2 == '0) begin
			x1_c = x0_s2;
		end else if (SIZE_W'(xi) >= w) begin
			x1_c = '0;
		end else begin
			x1_c = xi[X_W-1:0];
		end
		if (fy_s2 == '0) begin
			y1_c = y0_s2;
		end else if (SIZE_W'(yi) >= h) begin
			y1_c = '0;
		end else begin
			y1_c = yi[Y_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: take, sample: (cmd == CMD_SAMPLE), blank: !loaded};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= texel_index;
			word_s1 <= pack_texel(channel_count, byte0, byte1, byte2, byte3);
			fs_s1 <= coord_s[FRAC_BITS-1:0];
			ft_s1 <= coord_t[FRAC_BITS-1:0];

			idx_s2 <= idx_s1;
			word_s2 <= word_s1;
			x0_s2 <= x0_c;
			y0_s2 <= y0_c;
			fx_s2 <= fx_c;
			fy_s2 <= fy_c;

			idx_s3 <= idx_s2;
			word_s3 <= word_s2;
			raddr_s3[0] <= flat(x0_s2, y0_s2, w);
			raddr_s3[1] <= flat(x1_c, y0_s2, w);
			raddr_s3[2] <= flat(x0_s2, y1_c, w);
			raddr_s3[3] <= flat(x1_c, y1_c, w);
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/tsnb_filter.sv -----
// back stages: texel decode, horizontal and vertical blends, output register
`timescale 1ns / 1ps
`default_nettype none
module tsnb_filter import tsnb_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire tsnb_ctl_t      ctl_s3,
	input  wire frac_t          fx_s3,
	input  wire frac_t          fy_s3,
	input  wire word_t [3:0]    texel,
	output logic                out_valid,
	output rgba_t               rgba
);
	tsnb_ctl_t ctl_s4, ctl_s5;
	frac_t fx_s4, fy_s4, fy_s5;
	rgba_t top_s5, bot_s5;
	rgba_t t00, t10, t01, t11, top_c, bot_c, res_c;

	always_comb begin
		t00 = unpack_texel(texel[0]);
		t10 = unpack_texel(texel[1]);
		t01 = unpack_texel(texel[2]);
		t11 = unpack_texel(texel[3]);
		for (int k = 0; k < 4; k++) begin
			top_c[k] = blend(t00[k], t10[k], fx_s4);
			bot_c[k] = blend(t01[k], t11[k], fx_s4);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			res_c[k] = ctl_s5.blank ? '0 : blend(top_s5[k], bot_s5[k], fy_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			// write items leave the pipe as bubbles here
			ctl_s4 <= '{valid: ctl_s3.valid && ctl_s3.sample, sample: ctl_s3.sample,
				blank: ctl_s3.blank};
			ctl_s5 <= ctl_s4;
			out_valid <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			top_s5 <= top_c;
			bot_s5 <= bot_c;
			fy_s5 <= fy_s4;
			rgba <= res_c;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/texture_sampler_nearest_bilinear_unit.sv -----
// top level of the texture sampler: config registers, texel store banks, pipeline
`timescale 1ns / 1ps
`default_nettype none
// Texture sampler taking one item per clock unless the output stalls. A write
// item stores one texel (expanded to RGBA by the channel count) and gives no
// result; a sample item gives one RGBA result from the output register, by
// nearest or bilinear filtering of the stored texture. The throughput of one
// item per cycle comes from four copies of the 4096-entry texel store, all
// written together, so the four bilinear neighbors are read in the same cycle;
// the store needs no clearing pass after reset. A stalled output stalls the
// whole pipeline, so in_ready equals !out_valid || out_ready. Configuration may be
// written only while no item is in flight.
module texture_sampler_nearest_bilinear_unit import tsnb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 cmd,
	input  wire logic [IDX_W-1:0]     texel_index,
	input  wire logic [7:0]           byte0,
	input  wire logic [7:0]           byte1,
	input  wire logic [7:0]           byte2,
	input  wire logic [7:0]           byte3,
	input  wire logic signed [31:0]   coord_s,
	input  wire logic signed [31:0]   coord_t,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CH_W-1:0]           red,
	output logic [CH_W-1:0]           green,
	output logic [CH_W-1:0]           blue,
	output logic [CH_W-1:0]           alpha,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_data
);
	logic [SIZE_W-1:0] tex_width_q, tex_height_q;
	logic [2:0] channel_count_q;
	filt_t filter_mode_q;
	logic loaded_q;
	logic adv, take, we;
	logic [SIZE_W-1:0] w_c, h_c;

	tsnb_ctl_t ctl_s3;
	logic [IDX_W-1:0] idx_s3;
	word_t word_s3;
	logic [3:0][ADDR_W-1:0] raddr_s3;
	frac_t fx_s3, fy_s3;
	word_t [3:0] texel;
	rgba_t rgba;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign take = in_valid && in_ready;

	// zero is used as one, oversize as the maximum
	always_comb begin
		if (tex_width_q == '0) begin
			w_c = SIZE_W'(1);
		end else if (tex_width_q > SIZE_W'(MAX_WIDTH)) begin
			w_c = SIZE_W'(MAX_WIDTH);
		end else begin
			w_c = tex_width_q;
		end
		if (tex_height_q == '0) begin
			h_c = SIZE_W'(1);
		end else if (tex_height_q > SIZE_W'(MAX_HEIGHT)) begin
			h_c = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_c = tex_height_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q <= SIZE_W'(64);
			tex_height_q <= SIZE_W'(64);
			channel_count_q <= 3'd4;
			filter_mode_q <= FILT_NEAREST;
			loaded_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_WIDTH: tex_width_q <= cfg_data;
					REG_HEIGHT: tex_height_q <= cfg_data;
					REG_CHANNELS: channel_count_q <= cfg_data[2:0];
					REG_FILTER: filter_mode_q <= filt_t'(cfg_data[0]);
					default: ;
				endcase
			end
			if (take && cmd == CMD_WRITE) begin
				loaded_q <= 1'b1;
			end
		end
	end

	tsnb_addr u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.take(take),
		.cmd(cmd),
		.texel_index(texel_index),
		.byte0(byte0),
		.byte1(byte1),
		.byte2(byte2),
		.byte3(byte3),
		.coord_s(coord_s),
		.coord_t(coord_t),
		.w(w_c),
		.h(h_c),
		.channel_count(channel_count_q),
		.mode(filter_mode_q),
		.loaded(loaded_q),
		.ctl_s3(ctl_s3),
		.idx_s3(idx_s3),
		.word_s3(word_s3),
		.raddr_s3(raddr_s3),
		.fx_s3(fx_s3),
		.fy_s3(fy_s3)
	);

	// writes and reads share stage three, so item order is kept in the store
	assign we = adv && ctl_s3.valid && !ctl_s3.sample && (32'(idx_s3) < STORE_DEPTH);

	for (genvar i = 0; i < 4; i++) begin : g_bank
		tsnb_ram #(
			.WIDTH(WORD_W),
			.DEPTH(STORE_DEPTH)
		) u_bank (
			.clk(clk),
			.we(we),
			.waddr(ADDR_W'(idx_s3)),
			.wdata(word_s3),
			.re(adv),
			.raddr(raddr_s3[i]),
			.rdata(texel[i])
		);
	end

	tsnb_filter u_filter (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctl_s3(ctl_s3),
		.fx_s3(fx_s3),
		.fy_s3(fy_s3),
		.texel(texel),
		.out_valid(out_valid),
		.rgba(rgba)
	);

	assign red = rgba[0];
	assign green = rgba[1];
	assign blue = rgba[2];
	assign alpha = rgba[3];
endmodule
`default_nettype wire

// ----- hw/rtl/tsnb_checker.sv -----
// port checker for the texture sampler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "texture_sampler_nearest_bilinear_unit_assert.svh"
module tsnb_checker import tsnb_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            cmd,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic [CH_W-1:0] red,
	input wire logic [CH_W-1:0] green,
	input wire logic [CH_W-1:0] blue,
	input wire logic [CH_W-1:0] alpha
);
	logic seen_write_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_write_q <= 1'b0;
		end else if (in_valid && in_ready && cmd == CMD_WRITE) begin
			seen_write_q <= 1'b1;
		end
	end

	`TSNB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha), "stalled result changed")
	`TSNB_ASSERT(a_ready_free, clk, arst_n, (!out_valid || out_ready) |-> in_ready, "input not ready with free output")
	`TSNB_ASSERT(a_blank_first, clk, arst_n, out_valid && !seen_write_q |-> red == '0 && green == '0 && blue == '0 && alpha == '0, "sample before any write not zero")
	`TSNB_ASSERT(a_range, clk, arst_n, out_valid |-> red <= CH_W'(ONE_OUT) && green <= CH_W'(ONE_OUT) && blue <= CH_W'(ONE_OUT) && alpha <= CH_W'(ONE_OUT), "channel above one")
endmodule

bind texture_sampler_nearest_bilinear_unit tsnb_checker u_tsnb_checker (.*);
`default_nettype wire
